[design/load_cell_average_tare_scale_macros.svh]
`ifndef LOAD_CELL_AVERAGE_TARE_SCALE_MACROS_SVH
`define LOAD_CELL_AVERAGE_TARE_SCALE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define LCATS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define LCATS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lcats_pkg.sv]
package lcats_pkg;

    localparam int RawW   = 24;
    localparam int NetW   = 25;
    localparam int UnitsW = 32;
    localparam int SumW   = 32;
    localparam int CountW = 8;

    typedef logic [RawW-1:0]          raw_code_t;
    typedef logic signed [RawW-1:0]   avg_t;
    typedef logic signed [NetW-1:0]   net_t;
    typedef logic signed [UnitsW-1:0] units_t;
    typedef logic [1:0]               cfg_index_t;
    typedef logic [31:0]              cfg_data_t;

    localparam cfg_index_t REG_AVERAGE_COUNT = 2'd0;
    localparam cfg_index_t REG_TARE_OFFSET   = 2'd1;
    localparam cfg_index_t REG_SCALE_FACTOR  = 2'd2;

    localparam logic [CountW-1:0] AVERAGE_COUNT_RST = 8'd1;
    localparam logic [RawW-1:0]   TARE_OFFSET_RST   = 24'd119040;
    localparam logic [UnitsW-1:0] SCALE_FACTOR_RST  = 32'd81767;

    localparam logic [UnitsW-1:0] UNITS_MAX = 32'h7FFF_FFFF;
    localparam logic [UnitsW-1:0] UNITS_MIN = 32'h8000_0000;

endpackage

[design/load_cell_average_tare_scale.sv]
// Load cell averaging, tare and scaling.
// Input channel (s_valid/s_ready/s_raw_code): one 24-bit two's complement
// converter code per transfer. Codes are summed until average_count samples
// are in (zero counts as one); the sample that closes the window starts the
// arithmetic. Other samples are only added to the sum.
// Result channel (m_valid/m_ready): raw_average, net_value = average - tare,
// scaled_units = net * Q8.24 scale, truncated toward zero, saturated.
// After the closing transfer the block steps through the sum magnitude, the
// bit-serial restoring divider, average, net and magnitudes, the shift-add
// multiplier and a final step that saturates the units and loads the result.
// s_ready is low while that sequence runs, so no new sample is taken until
// the final step has handed its result to the output register.
// The result sits in an output register: the block goes on taking samples
// while m_ready is low, and holds the next result in its final step until
// the register frees up.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while idle. Unknown indexes are dropped.
// Reset (aresetn low, synchronous) restores the register defaults and
// empties the window and the output register.
`include "load_cell_average_tare_scale_macros.svh"

module load_cell_average_tare_scale (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lcats_pkg::raw_code_t   s_raw_code,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lcats_pkg::avg_t        m_raw_average,
    output lcats_pkg::net_t        m_net_value,
    output lcats_pkg::units_t      m_scaled_units,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  lcats_pkg::cfg_index_t  cfg_index,
    input  lcats_pkg::cfg_data_t   cfg_data
);
    import lcats_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SABS = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_AVG  = 3'd3;
    localparam logic [2:0] ST_NET  = 3'd4;
    localparam logic [2:0] ST_MAG  = 3'd5;
    localparam logic [2:0] ST_MUL  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [4:0] DIV_LAST = 5'd31;
    localparam logic [4:0] MUL_LAST = 5'd23;

    logic [2:0]         state_reg, state_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic [RawW-1:0]    tare_reg, tare_next;
    logic [UnitsW-1:0]  scale_reg, scale_next;
    logic [SumW-1:0]    sum_reg, sum_next;
    logic [CountW-1:0]  taken_reg, taken_next;
    logic [SumW-1:0]    quo_reg, quo_next;
    logic [CountW-1:0]  rem_reg, rem_next;
    logic [CountW-1:0]  divisor_reg, divisor_next;
    logic               neg_reg, neg_next;
    logic [4:0]         step_reg, step_next;
    logic [RawW-1:0]    avg_reg, avg_next;
    logic [NetW-1:0]    net_reg, net_next;
    logic [UnitsW-1:0]  mcand_reg, mcand_next;
    logic               mneg_reg, mneg_next;
    logic [UnitsW-1:0]  hi_reg, hi_next;
    logic [RawW-1:0]    lo_reg, lo_next;
    logic               mv_reg, mv_next;
    logic [RawW-1:0]    oavg_reg, oavg_next;
    logic [NetW-1:0]    onet_reg, onet_next;
    logic [UnitsW-1:0]  ounits_reg, ounits_next;

    logic               in_xfer;
    logic [SumW-1:0]    sum_add;
    logic [CountW-1:0]  taken_add;
    logic [CountW-1:0]  n_eff;
    logic               closes;
    logic [CountW:0]    div_shift;
    logic [CountW:0]    div_diff;
    logic               div_ge;
    logic [UnitsW:0]    mul_add;
    logic [NetW-1:0]    net_mag;
    logic [UnitsW-1:0]  units_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;

    assign sum_add   = sum_reg + {{(SumW-RawW){s_raw_code[RawW-1]}}, s_raw_code};
    assign taken_add = taken_reg + 8'd1;
    assign n_eff     = (count_reg == '0) ? 8'd1 : count_reg;
    assign closes    = (taken_add != '0) && (taken_add >= n_eff);

    // restoring divide: one quotient bit per cycle, dividend bits shift out of quo_reg
    assign div_shift = {rem_reg, quo_reg[SumW-1]};
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});

    // shift-add multiply, LSB of lo_reg selects the addend
    assign mul_add   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    assign net_mag   = net_reg[NetW-1] ? (~net_reg + 25'd1) : net_reg;

    always_comb begin
        // hi_reg holds |product| >> 24 after the last step
        if (neg_reg) begin
            units_val = hi_reg[UnitsW-1] ? UNITS_MIN : (~hi_reg + 32'd1);
        end else begin
            units_val = hi_reg[UnitsW-1] ? UNITS_MAX : hi_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        tare_next    = tare_reg;
        scale_next   = scale_reg;
        sum_next     = sum_reg;
        taken_next   = taken_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        avg_next     = avg_reg;
        net_next     = net_reg;
        mcand_next   = mcand_reg;
        mneg_next    = mneg_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        mv_next      = mv_reg;
        oavg_next    = oavg_reg;
        onet_next    = onet_reg;
        ounits_next  = ounits_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_AVERAGE_COUNT: count_next = cfg_data[CountW-1:0];
                REG_TARE_OFFSET:   tare_next  = cfg_data[RawW-1:0];
                REG_SCALE_FACTOR:  scale_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (closes) begin
                        sum_next     = '0;
                        taken_next   = '0;
                        quo_next     = sum_add;
                        divisor_next = taken_add;
                        state_next   = ST_SABS;
                    end else begin
                        sum_next   = sum_add;
                        taken_next = taken_add;
                    end
                end
            end
            ST_SABS: begin
                neg_next   = quo_reg[SumW-1];
                quo_next   = quo_reg[SumW-1] ? (~quo_reg + 32'd1) : quo_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                quo_next  = {quo_reg[SumW-2:0], div_ge};
                rem_next  = div_ge ? div_diff[CountW-1:0] : div_shift[CountW-1:0];
                step_next = step_reg + 5'd1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                // |quotient| <= 2^23, so 24 bits carry it either way
                avg_next   = neg_reg ? (~quo_reg[RawW-1:0] + 24'd1) : quo_reg[RawW-1:0];
                state_next = ST_NET;
            end
            ST_NET: begin
                net_next   = {avg_reg[RawW-1], avg_reg} - {tare_reg[RawW-1], tare_reg};
                mneg_next  = scale_reg[UnitsW-1];
                mcand_next = scale_reg[UnitsW-1] ? (~scale_reg + 32'd1) : scale_reg;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                lo_next    = net_mag[RawW-1:0];
                neg_next   = net_reg[NetW-1] ^ mneg_reg;
                hi_next    = '0;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                hi_next   = mul_add[UnitsW:1];
                lo_next   = {mul_add[0], lo_reg[RawW-1:1]};
                step_next = step_reg + 5'd1;
                if (step_reg == MUL_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    oavg_next   = avg_reg;
                    onet_next   = net_reg;
                    ounits_next = units_val;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= AVERAGE_COUNT_RST;
            tare_reg  <= TARE_OFFSET_RST;
            scale_reg <= SCALE_FACTOR_RST;
            sum_reg   <= '0;
            taken_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            tare_reg  <= tare_next;
            scale_reg <= scale_next;
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        step_reg    <= step_next;
        avg_reg     <= avg_next;
        net_reg     <= net_next;
        mcand_reg   <= mcand_next;
        mneg_reg    <= mneg_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        oavg_reg    <= oavg_next;
        onet_reg    <= onet_next;
        ounits_reg  <= ounits_next;
    end

    assign m_valid        = mv_reg;
    assign m_raw_average  = oavg_reg;
    assign m_net_value    = onet_reg;
    assign m_scaled_units = ounits_reg;

    `LCATS_ASSERT_NOW(a_rem_below_divisor, state_reg == ST_DIV, rem_reg < divisor_reg, "divider remainder not below divisor")
    `LCATS_ASSERT_NEXT(a_window_cleared, in_xfer && closes, taken_reg == '0 && sum_reg == '0, "window not cleared on close")
    `LCATS_ASSERT_NEXT(a_fin_delivers, state_reg == ST_FIN && !mv_reg, mv_reg && state_reg == ST_IDLE, "finished result not loaded")
    `LCATS_ASSERT_NOW(a_result_from_fin, $rose(mv_reg), $past(state_reg) == ST_FIN, "result appeared outside final step")

endmodule

[tb/sv/tb_load_cell_average_tare_scale.sv]
`timescale 1ns / 100ps

module tb_load_cell_average_tare_scale;
    import lcats_pkg::*;

    localparam int        HALF_PERIOD   = 6;
    localparam int        RESET_CYCLES  = 9;
    localparam int        SETTLE_CYCLES = 75;
    localparam int        IDLE_LIMIT    = 3000;
    localparam int        CODE_BUDGET   = 1950;
    localparam raw_code_t RAW_MAX       = 24'h7F_FFFF;
    localparam raw_code_t RAW_MIN       = 24'h80_0000;
    localparam cfg_index_t REG_UNUSED   = 2'd3;

    typedef enum {
        FILL_RANDOM,
        FILL_MAX,
        FILL_MIN,
        FILL_NEAR_TARE,
        FILL_EXTREMES,
        FILL_SMALL
    } fill_style_e;

    typedef struct {
        avg_t   raw_average;
        net_t   net_value;
        units_t scaled_units;
    } reading_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    raw_code_t  s_raw_code = '0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    avg_t       m_raw_average;
    net_t       m_net_value;
    units_t     m_scaled_units;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index  = REG_AVERAGE_COUNT;
    cfg_data_t  cfg_data   = '0;

    // predictor copy of registers and window state
    logic [7:0]  avg_count_cfg = AVERAGE_COUNT_RST;
    logic [23:0] tare_cfg      = TARE_OFFSET_RST;
    logic [31:0] scale_cfg     = SCALE_FACTOR_RST;
    logic [31:0] window_sum    = '0;
    logic [7:0]  window_fill   = '0;

    raw_code_t pending_codes[$];
    reading_t  readings_due[$];
    int        codes_queued   = 0;
    int        codes_accepted = 0;
    int        mismatches     = 0;
    int        send_gap       = 0;
    int        stall_left     = 0;
    int        idle_cycles    = 0;
    bit        steady         = 1'b0;

    load_cell_average_tare_scale dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_code     (s_raw_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_raw_average  (m_raw_average),
        .m_net_value    (m_net_value),
        .m_scaled_units (m_scaled_units),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 80);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // add one sample to the open window; close it and queue a reading when full
    task automatic accumulate_sample(input raw_code_t code);
        logic [7:0] need;
        longint     sum_v, fill_v, avg_v, tare_v, scale_v, net_v, prod_v, units_v;
        reading_t   r;
        need = (avg_count_cfg == 8'd0) ? 8'd1 : avg_count_cfg;
        window_sum  = window_sum + {{8{code[23]}}, code};
        window_fill = window_fill + 8'd1;
        if (window_fill == 8'd0 || window_fill < need)
            return;
        sum_v   = longint'($signed(window_sum));
        fill_v  = longint'(window_fill);
        avg_v   = sum_v / fill_v;
        tare_v  = longint'($signed(tare_cfg));
        scale_v = longint'($signed(scale_cfg));
        net_v   = avg_v - tare_v;
        prod_v  = net_v * scale_v;
        if (prod_v < 0)
            units_v = -((-prod_v) >>> 24);
        else
            units_v = prod_v >>> 24;
        if (units_v > 64'sd2147483647)
            units_v = 64'sd2147483647;
        if (units_v < -64'sd2147483648)
            units_v = -64'sd2147483648;
        r.raw_average  = avg_v[23:0];
        r.net_value    = net_v[24:0];
        r.scaled_units = units_v[31:0];
        readings_due.push_back(r);
        window_sum  = '0;
        window_fill = '0;
    endtask

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accumulate_sample(s_raw_code);
                codes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_codes.size() != 0) begin
                    s_raw_code <= pending_codes.pop_front();
                    s_valid    <= 1'b1;
                    send_gap    = next_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result transfer with no reading expected");
                end else begin
                    want = readings_due.pop_front();
                    if (m_raw_average !== want.raw_average)
                        report_mismatch($sformatf("raw_average %0d, want %0d",
                                                  m_raw_average, want.raw_average));
                    if (m_net_value !== want.net_value)
                        report_mismatch($sformatf("net_value %0d, want %0d",
                                                  m_net_value, want.net_value));
                    if (m_scaled_units !== want.scaled_units)
                        report_mismatch($sformatf("scaled_units %0d, want %0d",
                                                  m_scaled_units, want.scaled_units));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = next_gap();
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_load_cell_average_tare_scale: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_code(input raw_code_t code);
        pending_codes.push_back(code);
        codes_queued++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (codes_accepted != codes_queued || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_AVERAGE_COUNT: avg_count_cfg = data[7:0];
            REG_TARE_OFFSET:   tare_cfg      = data[23:0];
            REG_SCALE_FACTOR:  scale_cfg     = data;
            default: ;
        endcase
    endtask

    // upper bits of narrow registers carry random junk; they must be dropped
    task automatic write_count(input logic [7:0] cnt);
        cfg_data_t d;
        d = $urandom();
        d[7:0] = cnt;
        write_reg(REG_AVERAGE_COUNT, d);
    endtask

    task automatic write_tare(input logic [23:0] tare);
        cfg_data_t d;
        d = $urandom();
        d[23:0] = tare;
        write_reg(REG_TARE_OFFSET, d);
    endtask

    task automatic shuffle_tare_scale();
        cfg_data_t d;
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
                0: write_tare(RAW_MAX);
                1: write_tare(RAW_MIN);
                2: write_tare(24'd0);
                3: write_tare(TARE_OFFSET_RST);
                default: write_tare(24'($urandom()));
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 7))
                0: d = 32'h7FFF_FFFF;
                1: d = 32'h8000_0000;
                2: d = 32'd0;
                3: d = SCALE_FACTOR_RST;
                4: d = -SCALE_FACTOR_RST;
                5: d = 32'h0100_0000;
                default: d = $urandom();
            endcase
            write_reg(REG_SCALE_FACTOR, d);
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, $urandom());
    endtask

    task automatic queue_window(input int len, input fill_style_e style);
        raw_code_t c;
        for (int i = 0; i < len; i++) begin
            case (style)
                FILL_MAX:       c = RAW_MAX;
                FILL_MIN:       c = RAW_MIN;
                FILL_NEAR_TARE: c = tare_cfg + 24'($signed($urandom_range(0, 8191)) - 4096);
                FILL_EXTREMES: begin
                    case ($urandom_range(0, 3))
                        0: c = RAW_MAX;
                        1: c = RAW_MIN;
                        2: c = 24'hFF_FFFF;
                        default: c = 24'd0;
                    endcase
                end
                FILL_SMALL:     c = 24'($signed($urandom_range(0, 511)) - 256);
                default:        c = 24'($urandom());
            endcase
            queue_code(c);
        end
    endtask

    initial begin
        int          phase;
        int          cnt, eff, windows;
        fill_style_e style;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, one reading per sample
        queue_code(24'd0);
        queue_code(RAW_MAX);
        queue_code(RAW_MIN);
        queue_code(24'hFF_FFFF);
        queue_code(24'd1);
        queue_code(24'h80_0001);
        queue_code(TARE_OFFSET_RST);
        wait_idle();

        // zero count acts as one; widest positive net and scale
        write_count(8'd0);
        write_tare(RAW_MIN);
        write_reg(REG_SCALE_FACTOR, 32'h7FFF_FFFF);
        queue_code(RAW_MAX);
        queue_code(RAW_MIN);
        wait_idle();

        write_reg(REG_SCALE_FACTOR, 32'h8000_0000);
        write_tare(RAW_MAX);
        write_reg(REG_UNUSED, $urandom());
        queue_code(RAW_MIN);
        queue_code(RAW_MAX);
        queue_code(24'($urandom()));
        wait_idle();

        // count lowered while a window is open: closes on the next sample
        write_count(8'd10);
        queue_window(5, FILL_RANDOM);
        wait_idle();
        write_count(8'd3);
        queue_code(24'($urandom()));
        wait_idle();
        write_count(8'd2);
        queue_window(2, FILL_RANDOM);
        wait_idle();

        phase = 0;
        while (codes_queued < CODE_BUDGET) begin
            steady = ($urandom_range(0, 3) == 0);
            shuffle_tare_scale();
            if (phase == 0) begin
                cnt = 255;
                style = FILL_MAX;
            end else if (phase == 1) begin
                cnt = 255;
                style = FILL_MIN;
            end else begin
                case ($urandom_range(0, 19))
                    0:       cnt = 0;
                    1:       cnt = $urandom_range(200, 255);
                    2, 3, 4: cnt = $urandom_range(9, 40);
                    default: cnt = $urandom_range(1, 8);
                endcase
                style = fill_style_e'($urandom_range(0, 5));
            end
            write_count(cnt[7:0]);
            eff = (cnt == 0) ? 1 : cnt;
            windows = (eff > 120) ? 1 : 120 / eff;
            for (int w = 0; w < windows; w++) begin
                if (phase > 1 && $urandom_range(0, 2) == 0)
                    style = fill_style_e'($urandom_range(0, 5));
                queue_window(eff, style);
            end
            // leave a partial window open across the next register change
            if (eff > 1 && $urandom_range(0, 2) == 0)
                queue_window($urandom_range(1, eff - 1), FILL_RANDOM);
            wait_idle();
            phase++;
        end
        steady = 1'b0;
        wait_idle();

        if (mismatches == 0)
            $display("tb_load_cell_average_tare_scale: PASS");
        else
            $display("tb_load_cell_average_tare_scale: FAIL");
        $finish;
    end

endmodule
